[design/usbtd_pkg.sv]
// ----------------------------------------------------------------------------
// USB transfer descriptor builder package
// Shared types and control word fields for the descriptor chain builder.
// ----------------------------------------------------------------------------
package usbtd_pkg;

  // Requested transfer kinds.
  localparam logic [1:0] OP_CONTROL_READ  = 2'd0;
  localparam logic [1:0] OP_CONTROL_WRITE = 2'd1;
  localparam logic [1:0] OP_BULK_IN       = 2'd2;
  localparam logic [1:0] OP_BULK_OUT      = 2'd3;

  // Output record kinds.
  localparam logic [1:0] KIND_TRANSFER = 2'd0;
  localparam logic [1:0] KIND_ENDPOINT = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;

  // Direction / PID codes.
  localparam logic [1:0] DIR_SETUP = 2'd0;
  localparam logic [1:0] DIR_OUT   = 2'd1;
  localparam logic [1:0] DIR_IN    = 2'd2;

  // Transfer descriptor control word fields.
  localparam logic [31:0] CC_NOT_ACCESSED = 32'hE000_0000;
  localparam logic [31:0] DELAY_NONE      = 32'h00E0_0000;
  localparam logic [31:0] TOGGLE_DATA0    = 32'h0200_0000;
  localparam logic [31:0] TOGGLE_DATA1    = 32'h0300_0000;
  localparam logic [31:0] ROUNDING        = 32'h0004_0000;
  localparam int          DIR_SHIFT       = 19;
  localparam int          TOGGLE_SHIFT    = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SETUP,
    ST_DATA,
    ST_STATUS,
    ST_ENDPOINT
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_SETUP,
    EMIT_DATA,
    EMIT_STATUS,
    EMIT_ENDPOINT,
    EMIT_REJECT
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  count_step;
    logic  reload;
    emit_t emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ps_zero;
    logic over;
    logic count_done;
    logic is_control;
    logic data_pending;
    logic last_piece;
  } status_t;

endpackage

[design/usbtd_ctrl.sv]
// ----------------------------------------------------------------------------
// USB transfer descriptor builder controller
// Sequences the sizing pass and then one record per cycle of the chain.
// ----------------------------------------------------------------------------
module usbtd_ctrl
  import usbtd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        priority if (status.ps_zero || status.over) begin
          state_next = ST_IDLE;
        end else if (status.count_done) begin
          if (status.is_control) state_next = ST_SETUP;
          else if (status.data_pending) state_next = ST_DATA;
          else state_next = ST_ENDPOINT;
        end
      end
      ST_SETUP: begin
        state_next = status.data_pending ? ST_DATA : ST_STATUS;
      end
      ST_DATA: begin
        if (status.last_piece) begin
          state_next = status.is_control ? ST_STATUS : ST_ENDPOINT;
        end
      end
      ST_STATUS:   state_next = ST_ENDPOINT;
      ST_ENDPOINT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, count_step: 1'b0, reload: 1'b0, emit: EMIT_NONE};
    unique case (state)
      ST_IDLE: cmd.load = start;
      ST_COUNT: begin
        priority if (status.ps_zero || status.over) begin
          cmd.emit = EMIT_REJECT;
        end else if (status.count_done) begin
          cmd.reload = 1'b1;
        end else begin
          cmd.count_step = 1'b1;
        end
      end
      ST_SETUP:    cmd.emit = EMIT_SETUP;
      ST_DATA:     cmd.emit = EMIT_DATA;
      ST_STATUS:   cmd.emit = EMIT_STATUS;
      ST_ENDPOINT: cmd.emit = EMIT_ENDPOINT;
      default:     cmd.emit = EMIT_NONE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[design/usbtd_datapath.sv]
// ----------------------------------------------------------------------------
// USB transfer descriptor builder datapath
// Holds the request, sizes the data stage and forms each output record.
// ----------------------------------------------------------------------------
module usbtd_datapath
  import usbtd_pkg::*;
#(
  parameter int MAX_DESCRIPTORS  = 10,
  parameter int DESCRIPTOR_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [1:0]  operation,
  input  logic        low_speed,
  input  logic [6:0]  device_address,
  input  logic [3:0]  endpoint_number,
  input  logic [10:0] packet_size,
  input  logic [15:0] transfer_length,
  input  logic [31:0] buffer_address,
  input  logic [31:0] setup_address,
  input  logic [31:0] descriptor_base,
  output logic        strobe,
  output logic [1:0]  record_kind,
  output logic [31:0] word_control,
  output logic [31:0] word_buffer,
  output logic [31:0] word_next,
  output logic [31:0] word_end,
  output logic        last
);

  // The count never passes MAX_DESCRIPTORS + 1 before a reject is taken.
  localparam int CW = $clog2(MAX_DESCRIPTORS + 2);

  logic [1:0]    op;
  logic          ls;
  logic [6:0]    addr;
  logic [3:0]    ep;
  logic [10:0]   ps;
  logic [15:0]   len;
  logic [31:0]   setup;
  logic [31:0]   base;
  logic [31:0]   cur;
  logic [31:0]   slot_cur;
  logic [15:0]   remain;
  logic [CW-1:0] cnt;
  logic          toggle;

  logic          is_control;
  logic          has_data;
  logic [15:0]   ps_wide;
  logic [15:0]   piece;
  logic [31:0]   slot_next;

  assign is_control = (op == OP_CONTROL_READ) || (op == OP_CONTROL_WRITE);
  assign has_data   = (op != OP_CONTROL_WRITE);
  assign ps_wide    = {5'd0, ps};
  assign piece      = (remain > ps_wide) ? ps_wide : remain;
  assign slot_next  = slot_cur + 32'(DESCRIPTOR_BYTES);

  assign status.ps_zero      = (ps == 11'd0);
  assign status.over         = (cnt > CW'(MAX_DESCRIPTORS));
  assign status.count_done   = !has_data || (remain == 16'd0);
  assign status.is_control   = is_control;
  // Taken from the held length, since the sizing pass has used up remain.
  assign status.data_pending = has_data && (len != 16'd0);
  assign status.last_piece   = (remain <= ps_wide);

  // Request registers and the running chain position.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= operation;
      ls       <= low_speed;
      addr     <= device_address;
      ep       <= endpoint_number;
      ps       <= packet_size;
      len      <= transfer_length;
      setup    <= setup_address;
      base     <= descriptor_base;
      cur      <= buffer_address;
      slot_cur <= descriptor_base;
      remain   <= transfer_length;
      toggle   <= 1'b1;
      cnt      <= (operation == OP_CONTROL_READ || operation == OP_CONTROL_WRITE)
                  ? CW'(2) : CW'(0);
    end else if (cmd.count_step) begin
      // Sizing pass: one packet counted per cycle.
      remain <= remain - piece;
      cnt    <= cnt + CW'(1);
    end else if (cmd.reload) begin
      remain <= len;
    end else begin
      if (cmd.emit == EMIT_SETUP || cmd.emit == EMIT_DATA || cmd.emit == EMIT_STATUS) begin
        slot_cur <= slot_next;
      end
      if (cmd.emit == EMIT_DATA) begin
        remain <= remain - piece;
        cur    <= cur + 32'(ps);
        toggle <= ~toggle;
      end
    end
  end

  logic [31:0] data_dir;
  logic [31:0] data_extra;
  logic [1:0]  status_dir;
  logic [1:0]  ed_dir;
  logic [3:0]  ed_ep;

  always_comb begin
    data_dir   = (op == OP_CONTROL_READ) ? (32'(DIR_IN) << DIR_SHIFT) : 32'd0;
    data_extra = (op == OP_BULK_IN) ? ROUNDING : 32'd0;
    status_dir = (op == OP_CONTROL_READ) ? DIR_OUT : DIR_IN;
    if (is_control) begin
      ed_dir = DIR_SETUP;
      ed_ep  = 4'd0;
    end else begin
      ed_dir = (op == OP_BULK_IN) ? DIR_IN : DIR_OUT;
      ed_ep  = ep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_SETUP: begin
        record_kind  <= KIND_TRANSFER;
        word_control <= CC_NOT_ACCESSED | TOGGLE_DATA0 | DELAY_NONE
                        | (32'(DIR_SETUP) << DIR_SHIFT);
        word_buffer  <= setup;
        word_next    <= slot_next;
        word_end     <= setup + 32'd7;
        last         <= 1'b0;
      end
      EMIT_DATA: begin
        record_kind  <= KIND_TRANSFER;
        word_control <= CC_NOT_ACCESSED | (32'({1'b1, toggle}) << TOGGLE_SHIFT)
                        | DELAY_NONE | data_dir | data_extra;
        word_buffer  <= cur;
        word_next    <= slot_next;
        word_end     <= cur + 32'(piece) - 32'd1;
        last         <= 1'b0;
      end
      EMIT_STATUS: begin
        record_kind  <= KIND_TRANSFER;
        word_control <= CC_NOT_ACCESSED | TOGGLE_DATA1 | (32'(status_dir) << DIR_SHIFT);
        word_buffer  <= 32'd0;
        word_next    <= slot_next;
        word_end     <= 32'd0;
        last         <= 1'b0;
      end
      EMIT_ENDPOINT: begin
        // Tail is the slot just past the chain, head is the first slot.
        record_kind  <= KIND_ENDPOINT;
        word_control <= {5'd0, ps, 2'd0, ls, ed_dir, ed_ep, addr};
        word_buffer  <= slot_cur;
        word_next    <= base;
        word_end     <= 32'd0;
        last         <= 1'b1;
      end
      EMIT_REJECT: begin
        record_kind  <= KIND_REJECT;
        word_control <= 32'd0;
        word_buffer  <= 32'd0;
        word_next    <= 32'd0;
        word_end     <= 32'd0;
        last         <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/usb_transfer_descriptor_builder.sv]
// ----------------------------------------------------------------------------
// USB transfer descriptor builder
// Turns one transfer request into a chain of transfer descriptor records
// followed by the endpoint descriptor record.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block first
// sizes the data stage by stepping through the transfer one packet per cycle,
// then sends one record per cycle, each shown for a single cycle with strobe
// high and last marking the final record. Results cannot be held off, so the
// receiver must take every beat. A rejected request gives one reject record,
// which ends its sizing pass.
module usb_transfer_descriptor_builder
  import usbtd_pkg::*;
#(
  parameter int MAX_DESCRIPTORS  = 10,
  parameter int DESCRIPTOR_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic        low_speed,
  input  logic [6:0]  device_address,
  input  logic [3:0]  endpoint_number,
  input  logic [10:0] packet_size,
  input  logic [15:0] transfer_length,
  input  logic [31:0] buffer_address,
  input  logic [31:0] setup_address,
  input  logic [31:0] descriptor_base,
  output logic        strobe,
  output logic [1:0]  record_kind,
  output logic [31:0] word_control,
  output logic [31:0] word_buffer,
  output logic [31:0] word_next,
  output logic [31:0] word_end,
  output logic        last
);

  cmd_t    cmd;
  status_t status;

  usbtd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  usbtd_datapath #(
    .MAX_DESCRIPTORS  (MAX_DESCRIPTORS),
    .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .low_speed       (low_speed),
    .device_address  (device_address),
    .endpoint_number (endpoint_number),
    .packet_size     (packet_size),
    .transfer_length (transfer_length),
    .buffer_address  (buffer_address),
    .setup_address   (setup_address),
    .descriptor_base (descriptor_base),
    .strobe          (strobe),
    .record_kind     (record_kind),
    .word_control    (word_control),
    .word_buffer     (word_buffer),
    .word_next       (word_next),
    .word_end        (word_end),
    .last            (last)
  );

  // An accepted request always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // While a record that is not the last is shown, more work is still pending.
  a_more_records: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("chain stopped before its last record");

  // The last record of a request is never directly followed by another.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("record right after the last record");

  // A reject stands alone as the final record.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    strobe && record_kind == KIND_REJECT |-> last)
    else $error("reject record not marked last");

endmodule
